// ===== sv/icseq_pkg.sv =====
package icseq_pkg;

   localparam int unsigned CfgDataWidth = 16;
   localparam int unsigned CfgIndexWidth = 3;
   localparam int unsigned DutyWidth = 8;
   localparam int unsigned WeightWidth = 10;
   localparam int unsigned PosWidth = 32;

   // sequence state codes
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SEND = 2'd1;
   localparam logic [1:0] ST_RECV = 2'd2;

   // command codes
   localparam logic [1:0] OP_NONE  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_STOP  = 2'd2;
   localparam logic [1:0] OP_CAL   = 2'd3;

   // register indexes
   localparam logic [CfgIndexWidth-1:0] CSR_CONVEYOR_SPEED  = 3'd0;
   localparam logic [CfgIndexWidth-1:0] CSR_TEETH_SPEED     = 3'd1;
   localparam logic [CfgIndexWidth-1:0] CSR_INTAKE_SPEED    = 3'd2;
   localparam logic [CfgIndexWidth-1:0] CSR_SEND_TIME_MS    = 3'd3;
   localparam logic [CfgIndexWidth-1:0] CSR_TEETH_WEIGHT    = 3'd4;
   localparam logic [CfgIndexWidth-1:0] CSR_CONVEYOR_WEIGHT = 3'd5;

   localparam logic [DutyWidth-1:0]   RST_CONVEYOR_SPEED  = 8'd230;
   localparam logic [DutyWidth-1:0]   RST_TEETH_SPEED     = 8'd80;
   localparam logic [DutyWidth-1:0]   RST_INTAKE_SPEED    = 8'd230;
   localparam logic [15:0]            RST_SEND_TIME_MS    = 16'd2000;
   localparam logic [WeightWidth-1:0] RST_TEETH_WEIGHT    = 10'd567;
   localparam logic [WeightWidth-1:0] RST_CONVEYOR_WEIGHT = 10'd874;

   typedef struct packed {
      logic [DutyWidth-1:0]   conveyor_speed;
      logic [DutyWidth-1:0]   teeth_speed;
      logic [DutyWidth-1:0]   intake_speed;
      logic [15:0]            send_time_ms;
      logic [WeightWidth-1:0] teeth_weight;
      logic [WeightWidth-1:0] conveyor_weight;
   } cfg_type;

   // effective count step after saturation
   typedef struct packed {
      logic up;
      logic dn;
   } step_type;

   typedef struct packed {
      logic [DutyWidth-1:0] conveyor_drive;
      logic [DutyWidth-1:0] teeth_drive;
      logic [DutyWidth-1:0] intake_drive;
      logic [1:0]           sequence_state;
      logic                 complete_pulse;
   } seq_out_type;

endpackage

// ===== sv/icseq_enc.sv =====
module icseq_enc import icseq_pkg::*; #(
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          clr,
   input  logic                          pin_a,
   input  logic                          pin_b,
   output logic signed [COUNT_WIDTH-1:0] count_ff,
   output logic signed [COUNT_WIDTH-1:0] count_in,
   output step_type                      step
);

   localparam logic signed [COUNT_WIDTH-1:0] CntMax = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
   localparam logic signed [COUNT_WIDTH-1:0] CntMin = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

   logic a_prev_ff;
   logic b_prev_ff;
   logic chg_a;
   logic chg_b;
   logic raw_up;
   logic raw_dn;

   assign chg_a = a_prev_ff != pin_a;
   assign chg_b = b_prev_ff != pin_b;

   // x4 decode; both pins moving at once is an invalid step
   assign raw_up = (chg_a && !chg_b && (pin_a == pin_b)) ||
                   (chg_b && !chg_a && (pin_a != pin_b));
   assign raw_dn = (chg_a && !chg_b && (pin_a != pin_b)) ||
                   (chg_b && !chg_a && (pin_a == pin_b));

   assign step.up = raw_up && (count_ff != CntMax);
   assign step.dn = raw_dn && (count_ff != CntMin);

   always_comb begin
      if (clr) begin
         count_in = '0;
      end else if (step.up) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end else if (step.dn) begin
         count_in = count_ff - COUNT_WIDTH'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         a_prev_ff <= 1'b0;
         b_prev_ff <= 1'b0;
      end else if (adv) begin
         count_ff  <= count_in;
         a_prev_ff <= pin_a;
         b_prev_ff <= pin_b;
      end
   end

endmodule

// ===== sv/icseq_ctrl.sv =====
module icseq_ctrl import icseq_pkg::*; #(
   parameter int unsigned COUNT_WIDTH = 32,
   parameter int unsigned TIMER_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  cfg_type                       cfg,
   input  logic [1:0]                    operation,
   input  logic                          ms_tick,
   input  logic                          beam_level,
   input  logic signed [COUNT_WIDTH-1:0] conv_count,
   input  step_type                      conv_step,
   input  logic signed [COUNT_WIDTH-1:0] teeth_count,
   input  step_type                      teeth_step,
   output logic                          cnt_clr,
   output seq_out_type                   res_in
);

   localparam int unsigned ProdWidth = COUNT_WIDTH + WeightWidth + 1;
   localparam int unsigned CmpWidth = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

   logic [1:0]             seq_ff;
   logic [1:0]             seq_in;
   logic [TIMER_WIDTH-1:0] elapsed_ff;
   logic [TIMER_WIDTH-1:0] elapsed_in;
   logic [DutyWidth-1:0]   conv_duty_ff;
   logic [DutyWidth-1:0]   conv_duty_in;
   logic [DutyWidth-1:0]   teeth_duty_ff;
   logic [DutyWidth-1:0]   teeth_duty_in;
   logic [DutyWidth-1:0]   intake_duty_ff;
   logic [DutyWidth-1:0]   intake_duty_in;
   logic                   beam_prev_ff;

   logic signed [WeightWidth:0]   tw_s;
   logic signed [WeightWidth:0]   cw_s;
   logic signed [ProdWidth-1:0]   t_prod;
   logic signed [ProdWidth-1:0]   c_prod;
   logic signed [ProdWidth-1:0]   t_pos;
   logic signed [ProdWidth-1:0]   c_pos;
   logic                          teeth_ahead;

   // products of the stored counts, corrected by this item's step
   assign tw_s   = $signed({1'b0, cfg.teeth_weight});
   assign cw_s   = $signed({1'b0, cfg.conveyor_weight});
   assign t_prod = ProdWidth'(teeth_count) * ProdWidth'(tw_s);
   assign c_prod = ProdWidth'(conv_count) * ProdWidth'(cw_s);

   always_comb begin
      t_pos = t_prod;
      c_pos = c_prod;
      if (teeth_step.up) begin
         t_pos = t_prod + ProdWidth'(tw_s);
      end else if (teeth_step.dn) begin
         t_pos = t_prod - ProdWidth'(tw_s);
      end
      if (conv_step.up) begin
         c_pos = c_prod + ProdWidth'(cw_s);
      end else if (conv_step.dn) begin
         c_pos = c_prod - ProdWidth'(cw_s);
      end
   end

   // after calibrate both counts are zero, so teeth is never ahead
   assign teeth_ahead = (operation != OP_CAL) && (t_pos > c_pos);

   always_comb begin
      logic [TIMER_WIDTH-1:0] el;
      logic [1:0]             st;
      logic                   clr;
      logic                   done;
      el   = elapsed_ff;
      st   = seq_ff;
      clr  = 1'b0;
      done = 1'b0;
      conv_duty_in   = conv_duty_ff;
      teeth_duty_in  = teeth_duty_ff;
      intake_duty_in = intake_duty_ff;

      if (ms_tick && (seq_ff == ST_SEND) && (elapsed_ff != {TIMER_WIDTH{1'b1}})) begin
         el = elapsed_ff + TIMER_WIDTH'(1);
      end

      case (operation)
         OP_START: begin
            intake_duty_in = cfg.intake_speed;
            el = '0;
            st = ST_SEND;
         end
         OP_STOP: begin
            conv_duty_in   = '0;
            teeth_duty_in  = '0;
            intake_duty_in = '0;
            st = ST_IDLE;
         end
         OP_CAL: begin
            intake_duty_in = '0;
            conv_duty_in   = cfg.conveyor_speed;
            teeth_duty_in  = cfg.teeth_speed;
            clr = 1'b1;
            st  = ST_RECV;
         end
         default: begin
         end
      endcase

      // only one of conveyor and teeth runs in receive, but the send timeout starts both
      if (st == ST_RECV) begin
         if (teeth_ahead) begin
            conv_duty_in  = cfg.conveyor_speed;
            teeth_duty_in = '0;
         end else begin
            conv_duty_in  = '0;
            teeth_duty_in = cfg.teeth_speed;
         end
      end

      if ((st == ST_SEND) && (CmpWidth'(el) > CmpWidth'(cfg.send_time_ms))) begin
         intake_duty_in = '0;
         conv_duty_in   = cfg.conveyor_speed;
         teeth_duty_in  = cfg.teeth_speed;
         clr = 1'b1;
         st  = ST_RECV;
      end

      if (!beam_level && beam_prev_ff && (st == ST_RECV)) begin
         conv_duty_in  = '0;
         teeth_duty_in = '0;
         st   = ST_IDLE;
         done = 1'b1;
      end

      elapsed_in = el;
      seq_in     = st;
      cnt_clr    = clr;
      res_in.conveyor_drive = conv_duty_in;
      res_in.teeth_drive    = teeth_duty_in;
      res_in.intake_drive   = intake_duty_in;
      res_in.sequence_state = st;
      res_in.complete_pulse = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff         <= ST_IDLE;
         elapsed_ff     <= '0;
         conv_duty_ff   <= '0;
         teeth_duty_ff  <= '0;
         intake_duty_ff <= '0;
         beam_prev_ff   <= 1'b0;
      end else if (adv) begin
         seq_ff         <= seq_in;
         elapsed_ff     <= elapsed_in;
         conv_duty_ff   <= conv_duty_in;
         teeth_duty_ff  <= teeth_duty_in;
         intake_duty_ff <= intake_duty_in;
         beam_prev_ff   <= beam_level;
      end
   end

endmodule

// ===== sv/intake_conveyor_sequencer.sv =====
// Intake conveyor sequencer.
// Request channel (req_*): one sample per transfer of both quadrature encoder
// pin pairs, the beam-break level, a millisecond tick and a command.
// Response channel (rsp_*): exactly one transfer per request, in order, with
// the three motor duties, the sequence state, the complete pulse and both
// encoder positions after that sample.
// Configuration (csr_*): six registers written by index, one per cycle; the
// user must write them only while no request is in flight; the block does
// not enforce it. A request is captured in the input register and then moves
// into the result register. Throughput: one request per cycle while rsp_stall
// is low; the path through one x10-bit multiply and a product compare sets
// the cycle time. Reset clears the sequence to idle, counts, timer and
// duties to zero and loads the register defaults. While rsp_stall is high
// the response holds; one more request can still be taken into the input
// register, after which req_stall rises until the response is transferred.
module intake_conveyor_sequencer import icseq_pkg::*; #(
   parameter int unsigned COUNT_WIDTH = 32,
   parameter int unsigned TIMER_WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CfgIndexWidth-1:0] csr_index,
   input  logic [CfgDataWidth-1:0]  csr_wdata,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_operation,
   input  logic                     req_ms_tick,
   input  logic                     req_conv_a,
   input  logic                     req_conv_b,
   input  logic                     req_teeth_a,
   input  logic                     req_teeth_b,
   input  logic                     req_beam_level,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [DutyWidth-1:0]     rsp_conveyor_drive,
   output logic [DutyWidth-1:0]     rsp_teeth_drive,
   output logic [DutyWidth-1:0]     rsp_intake_drive,
   output logic [1:0]               rsp_sequence_state,
   output logic                     rsp_complete_pulse,
   output logic signed [PosWidth-1:0] rsp_conveyor_position,
   output logic signed [PosWidth-1:0] rsp_teeth_position
);

   cfg_type     cfg_ff;
   logic        in_vld_ff;
   logic        in_vld_in;
   logic [1:0]  in_op_ff;
   logic        in_tick_ff;
   logic        in_ca_ff;
   logic        in_cb_ff;
   logic        in_ta_ff;
   logic        in_tb_ff;
   logic        in_beam_ff;
   logic        out_vld_ff;
   logic        out_vld_in;
   seq_out_type res_ff;
   seq_out_type res_in;
   logic signed [PosWidth-1:0] conv_pos_ff;
   logic signed [PosWidth-1:0] teeth_pos_ff;

   logic adv;
   logic req_xfer;
   logic cnt_clr;
   logic signed [COUNT_WIDTH-1:0] conv_cnt_ff;
   logic signed [COUNT_WIDTH-1:0] conv_cnt_in;
   logic signed [COUNT_WIDTH-1:0] teeth_cnt_ff;
   logic signed [COUNT_WIDTH-1:0] teeth_cnt_in;
   logic signed [63:0] conv_ext;
   logic signed [63:0] teeth_ext;
   step_type conv_step;
   step_type teeth_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.conveyor_speed  <= RST_CONVEYOR_SPEED;
         cfg_ff.teeth_speed     <= RST_TEETH_SPEED;
         cfg_ff.intake_speed    <= RST_INTAKE_SPEED;
         cfg_ff.send_time_ms    <= RST_SEND_TIME_MS;
         cfg_ff.teeth_weight    <= RST_TEETH_WEIGHT;
         cfg_ff.conveyor_weight <= RST_CONVEYOR_WEIGHT;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CONVEYOR_SPEED:  cfg_ff.conveyor_speed  <= csr_wdata[DutyWidth-1:0];
            CSR_TEETH_SPEED:     cfg_ff.teeth_speed     <= csr_wdata[DutyWidth-1:0];
            CSR_INTAKE_SPEED:    cfg_ff.intake_speed    <= csr_wdata[DutyWidth-1:0];
            CSR_SEND_TIME_MS:    cfg_ff.send_time_ms    <= csr_wdata;
            CSR_TEETH_WEIGHT:    cfg_ff.teeth_weight    <= csr_wdata[WeightWidth-1:0];
            CSR_CONVEYOR_WEIGHT: cfg_ff.conveyor_weight <= csr_wdata[WeightWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   // item moves from the input register into the result register
   assign adv       = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !adv;
   assign req_xfer  = req_valid && !req_stall;

   assign in_vld_in  = req_xfer || (in_vld_ff && !adv);
   assign out_vld_in = adv || (out_vld_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_op_ff   <= req_operation;
         in_tick_ff <= req_ms_tick;
         in_ca_ff   <= req_conv_a;
         in_cb_ff   <= req_conv_b;
         in_ta_ff   <= req_teeth_a;
         in_tb_ff   <= req_teeth_b;
         in_beam_ff <= req_beam_level;
      end
   end

   icseq_enc #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_conv_enc (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .clr      (cnt_clr),
      .pin_a    (in_ca_ff),
      .pin_b    (in_cb_ff),
      .count_ff (conv_cnt_ff),
      .count_in (conv_cnt_in),
      .step     (conv_step)
   );

   icseq_enc #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_teeth_enc (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .clr      (cnt_clr),
      .pin_a    (in_ta_ff),
      .pin_b    (in_tb_ff),
      .count_ff (teeth_cnt_ff),
      .count_in (teeth_cnt_in),
      .step     (teeth_step)
   );

   icseq_ctrl #(
      .COUNT_WIDTH(COUNT_WIDTH),
      .TIMER_WIDTH(TIMER_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .cfg         (cfg_ff),
      .operation   (in_op_ff),
      .ms_tick     (in_tick_ff),
      .beam_level  (in_beam_ff),
      .conv_count  (conv_cnt_ff),
      .conv_step   (conv_step),
      .teeth_count (teeth_cnt_ff),
      .teeth_step  (teeth_step),
      .cnt_clr     (cnt_clr),
      .res_in      (res_in)
   );

   // positions report the low 32 bits of the sign-extended count
   assign conv_ext  = 64'(conv_cnt_in);
   assign teeth_ext = 64'(teeth_cnt_in);

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff       <= res_in;
         conv_pos_ff  <= conv_ext[PosWidth-1:0];
         teeth_pos_ff <= teeth_ext[PosWidth-1:0];
      end
   end

   assign rsp_valid             = out_vld_ff;
   assign rsp_conveyor_drive    = res_ff.conveyor_drive;
   assign rsp_teeth_drive       = res_ff.teeth_drive;
   assign rsp_intake_drive      = res_ff.intake_drive;
   assign rsp_sequence_state    = res_ff.sequence_state;
   assign rsp_complete_pulse    = res_ff.complete_pulse;
   assign rsp_conveyor_position = conv_pos_ff;
   assign rsp_teeth_position    = teeth_pos_ff;

endmodule
